// File: sv/oidd_pkg.sv
`timescale 1ns / 1ps

package oidd_pkg;

	// Widths and limits of the decoder.
	localparam int ARC_VALUE_BITS = 64;
	localparam int MAX_ARCS = 511;
	localparam int IDX_W = 9;
	localparam int IDX_CAP = (MAX_ARCS < 511) ? MAX_ARCS : 511;
	localparam int WB_MAX = ARC_VALUE_BITS / 8;
	localparam int OCT_W = 4;
	localparam int OCT_SAT = 15;

	// Register reset values.
	localparam logic [3:0] AWB_RESET = 4'd8;
	localparam logic [8:0] SLOTS_RESET = 9'd511;

	// Register selects, taken from paddr[2].
	localparam logic REG_AWB = 1'b0;
	localparam logic REG_SLOTS = 1'b1;

	// Status codes of a result word.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_OPEN = 2'd2;

	// One result word.
	typedef struct packed {
		logic [ARC_VALUE_BITS-1:0] arc_value;
		logic [IDX_W-1:0] arc_index;
		logic arc_valid;
		logic arc_stored;
		logic [1:0] status;
		logic oid_end;
		logic run_last;
	} res_t;

	// What one accepted octet produces: up to two words.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic [1:0] n;
	} step_t;

	// Configuration as seen by the decode logic.
	typedef struct packed {
		logic [3:0] arc_width_bytes;
		logic [8:0] slot_limit;
	} cfg_t;

endpackage

// File: sv/oidd_ifs.sv
`timescale 1ns / 1ps

// Octet channel.
interface oidd_octet_if;
	logic valid;
	logic ready;
	logic [7:0] content_byte;
	logic last_byte;

	modport source (output valid, output content_byte, output last_byte, input ready);
	modport sink (input valid, input content_byte, input last_byte, output ready);
endinterface

// Arc result channel.
interface oidd_arc_if;
	logic valid;
	logic ready;
	logic [oidd_pkg::ARC_VALUE_BITS-1:0] arc_value;
	logic [oidd_pkg::IDX_W-1:0] arc_index;
	logic arc_valid;
	logic arc_stored;
	logic [1:0] status;
	logic oid_end;
	logic run_last;

	modport source (output valid, output arc_value, output arc_index, output arc_valid,
		output arc_stored, output status, output oid_end, output run_last, input ready);
	modport sink (input valid, input arc_value, input arc_index, input arc_valid,
		input arc_stored, input status, input oid_end, input run_last, output ready);
endinterface

// File: sv/oidd_step.sv
`timescale 1ns / 1ps

// Per-octet decode: holds the arc state and forms the words for one octet.
module oidd_step (
	input logic clk,
	input logic arst_n,
	input oidd_pkg::cfg_t cfg,
	input logic take,
	input logic [7:0] content_byte,
	input logic last_byte,
	output oidd_pkg::step_t step
);

	localparam int AW = oidd_pkg::ARC_VALUE_BITS;
	localparam int IW = oidd_pkg::IDX_W;

	logic [AW-1:0] acc_q;
	logic ovf_q;
	logic [oidd_pkg::OCT_W-1:0] oct_q;
	logic [IW-1:0] seen_q;
	logic err_q;

	logic [3:0] wb;
	logic [6:0] wbits;
	logic [AW-1:0] mask;
	logic [AW-1:0] hi;
	logic [AW-1:0] acc_sh;
	logic ovf_now;
	logic [oidd_pkg::OCT_W-1:0] oct_n;
	logic end_arc;
	logic first_sub;
	logic [1:0] first;
	logic [AW-1:0] sub;
	logic under;
	logic ovf2;
	logic ovf_res;
	logic err_eff;
	logic [IW-1:0] seen1;
	logic [IW-1:0] seen2;
	logic st0;
	logic st1;
	logic [AW-1:0] second;

	// Effective arc width in bits, and the masks that go with it.
	always_comb begin
		if (cfg.arc_width_bytes == 4'd0) begin
			wb = 4'd1;
		end else if (32'(cfg.arc_width_bytes) > oidd_pkg::WB_MAX) begin
			wb = 4'(oidd_pkg::WB_MAX);
		end else begin
			wb = cfg.arc_width_bytes;
		end
		wbits = {wb, 3'b000};
		if (32'(wbits) > AW) begin
			wbits = 7'(AW);
		end
		for (int i = 0; i < AW; i++) begin
			mask[i] = (i < 32'(wbits));
			hi[i] = (i + 7 >= 32'(wbits));
		end
	end

	function automatic logic slot_ok(input logic [IW-1:0] idx, input logic [8:0] slots);
		slot_ok = (32'(idx) < 32'(slots)) && (32'(idx) < oidd_pkg::MAX_ARCS);
	endfunction

	function automatic logic [IW-1:0] sat_inc(input logic [IW-1:0] v);
		sat_inc = (32'(v) >= oidd_pkg::IDX_CAP) ? v : v + IW'(1);
	endfunction

	// Shift the octet in and split the first subidentifier.
	always_comb begin
		acc_sh = {acc_q[AW-8:0], content_byte[6:0]} & mask;
		ovf_now = ovf_q | (|(acc_q & hi));
		oct_n = (32'(oct_q) < oidd_pkg::OCT_SAT) ? oct_q + 1'b1 : oct_q;
		end_arc = ~content_byte[7];
		first_sub = (seen_q == '0);

		if (oct_n > 4'd1) begin
			first = 2'd2;
		end else if (acc_sh <= AW'(39)) begin
			first = 2'd0;
		end else if (acc_sh <= AW'(79)) begin
			first = 2'd1;
		end else begin
			first = 2'd2;
		end
		case (first)
			2'd0: sub = '0;
			2'd1: sub = AW'(40);
			default: sub = AW'(80);
		endcase
		under = acc_sh < sub;
		ovf2 = ovf_now | under;
		second = ovf2 ? '0 : acc_sh - sub;

		ovf_res = first_sub ? ovf2 : ovf_now;
		err_eff = err_q | (end_arc & ovf_res);
		seen1 = sat_inc(seen_q);
		seen2 = sat_inc(seen1);
		st0 = slot_ok(seen_q, cfg.slot_limit);
		st1 = slot_ok(seen1, cfg.slot_limit);
	end

	// Assemble the words for this octet.
	always_comb begin
		step = '0;
		step.r0.arc_index = seen_q;
		step.r1.arc_index = seen1;
		if (end_arc) begin
			step.r0.arc_valid = 1'b1;
			step.r0.arc_stored = st0;
			step.r0.status = err_eff ? oidd_pkg::ST_OVF : oidd_pkg::ST_OK;
			if (first_sub) begin
				step.r0.arc_value = st0 ? AW'(first) : '0;
				step.r1.arc_valid = 1'b1;
				step.r1.arc_stored = st1;
				step.r1.arc_value = (st1 && !ovf2) ? second : '0;
				step.r1.status = err_eff ? oidd_pkg::ST_OVF : oidd_pkg::ST_OK;
				step.r1.oid_end = last_byte;
				step.r1.run_last = 1'b1;
				step.n = 2'd2;
			end else begin
				step.r0.arc_value = (st0 && !ovf_now) ? acc_sh : '0;
				step.r0.oid_end = last_byte;
				step.r0.run_last = 1'b1;
				step.n = 2'd1;
			end
		end else if (last_byte) begin
			// Identifier ends inside an arc: one marker word.
			step.r0.status = oidd_pkg::ST_OPEN;
			step.r0.oid_end = 1'b1;
			step.r0.run_last = 1'b1;
			step.n = 2'd1;
		end
	end

	// Arc state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
			oct_q <= '0;
			seen_q <= '0;
			err_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
				oct_q <= '0;
				seen_q <= '0;
				err_q <= 1'b0;
			end else if (end_arc) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
				oct_q <= '0;
				seen_q <= first_sub ? seen2 : seen1;
				err_q <= err_eff;
			end else begin
				acc_q <= acc_sh;
				ovf_q <= ovf_now;
				oct_q <= oct_n;
			end
		end
	end

endmodule

// File: sv/oid_arc_decoder.sv
`timescale 1ns / 1ps

// BER object identifier arc decoder.
// The octet channel takes the content octets of an identifier, one word per
// cycle while octet ready is high, with last_byte on the final octet. The arc
// channel returns one word per finished arc; the first subidentifier gives
// two words, and an identifier that ends inside an arc gives one marker word
// with status 2. A continuation octet that is not the last gives no word.
// With nothing queued ahead, the words of an octet are visible on the arc
// channel in the cycle after it is accepted. Words leave through a
// three-entry queue, one per cycle while the receiver is ready, so the block
// takes one octet per cycle while octets give at most one word each; the
// first arc's extra word stalls the octet channel until the queue has drained
// back to one word. Octet ready is high while the queue holds at most one word.
// When the receiver stalls, the queue fills and octet ready drops; no word
// is lost. Reset empties the queue, clears the arc state and sets
// arc_width_bytes to 8 and the slot limit to 511. Registers are written over
// the APB port at byte address 0 (arc width) and 4 (slot limit); the user
// writes them only while the block is idle, which the block does not enforce.
module oid_arc_decoder (
	input logic clk,
	input logic arst_n,
	oidd_octet_if.sink octet,
	oidd_arc_if.source arc,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	oidd_pkg::cfg_t cfg_q;
	oidd_pkg::step_t step;
	oidd_pkg::res_t q_q [3];
	oidd_pkg::res_t nq [3];
	logic [1:0] cnt_q;
	logic [1:0] cnt_n;
	logic [1:0] base;
	logic push;
	logic pop;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arc_width_bytes <= oidd_pkg::AWB_RESET;
			cfg_q.slot_limit <= oidd_pkg::SLOTS_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				oidd_pkg::REG_AWB: cfg_q.arc_width_bytes <= pwdata[3:0];
				oidd_pkg::REG_SLOTS: cfg_q.slot_limit <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			oidd_pkg::REG_AWB: prdata = {28'd0, cfg_q.arc_width_bytes};
			oidd_pkg::REG_SLOTS: prdata = {23'd0, cfg_q.slot_limit};
			default: prdata = '0;
		endcase
	end

	// Decode of the accepted octet.
	assign octet.ready = (cnt_q <= 2'd1);
	assign push = octet.valid && octet.ready;

	oidd_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.take(push),
		.content_byte(octet.content_byte),
		.last_byte(octet.last_byte),
		.step(step)
	);

	// Result queue: pop shifts down, new words land after what remains.
	assign pop = (cnt_q != 2'd0) && arc.ready;

	always_comb begin
		nq = q_q;
		if (pop) begin
			nq[0] = q_q[1];
			nq[1] = q_q[2];
		end
		base = cnt_q - {1'b0, pop};
		cnt_n = base;
		if (push) begin
			if (step.n != 2'd0) begin
				nq[base] = step.r0;
			end
			if (step.n == 2'd2) begin
				nq[base + 2'd1] = step.r1;
			end
			cnt_n = base + step.n;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= nq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	assign arc.valid = (cnt_q != 2'd0);
	assign arc.arc_value = q_q[0].arc_value;
	assign arc.arc_index = q_q[0].arc_index;
	assign arc.arc_valid = q_q[0].arc_valid;
	assign arc.arc_stored = q_q[0].arc_stored;
	assign arc.status = q_q[0].status;
	assign arc.oid_end = q_q[0].oid_end;
	assign arc.run_last = q_q[0].run_last;

endmodule

// File: sv/oidd_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the arc decoder.
module oidd_sva (
	input logic clk,
	input logic arst_n,
	input logic octet_valid,
	input logic octet_ready,
	input logic octet_b7,
	input logic octet_last,
	input logic arc_vld,
	input logic arc_rdy,
	input logic [oidd_pkg::ARC_VALUE_BITS-1:0] arc_value,
	input logic [oidd_pkg::IDX_W-1:0] arc_index,
	input logic arc_valid,
	input logic arc_stored,
	input logic [1:0] status,
	input logic oid_end,
	input logic run_last
);

	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		arc_vld && !arc_rdy |=> arc_vld && $stable(arc_value) && $stable(arc_index)
			&& $stable(status) && $stable(oid_end))
		else $error("stalled arc word changed");

	// An octet that ends an arc or the identifier yields a word next cycle.
	a_word: assert property (@(posedge clk) disable iff (!arst_n)
		octet_valid && octet_ready && (!octet_b7 || octet_last) |=> arc_vld)
		else $error("missing word after an ending octet");

	// A marker word carries no arc and reports an open trailing arc.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		arc_vld && !arc_valid |-> status == oidd_pkg::ST_OPEN && !arc_stored
			&& arc_value == '0 && oid_end)
		else $error("malformed marker word");

	// The end of an identifier is always the last word of its octet.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		arc_vld && oid_end |-> run_last)
		else $error("identifier end not on the last word of its octet");

endmodule

bind oid_arc_decoder oidd_sva u_oidd_sva (
	.clk(clk),
	.arst_n(arst_n),
	.octet_valid(octet.valid),
	.octet_ready(octet.ready),
	.octet_b7(octet.content_byte[7]),
	.octet_last(octet.last_byte),
	.arc_vld(arc.valid),
	.arc_rdy(arc.ready),
	.arc_value(arc.arc_value),
	.arc_index(arc.arc_index),
	.arc_valid(arc.arc_valid),
	.arc_stored(arc.arc_stored),
	.status(arc.status),
	.oid_end(arc.oid_end),
	.run_last(arc.run_last)
);
